### sv/bdeq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
`timescale 1ns / 1ps

package bdeq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;
    localparam int CAP_W      = 5;
    localparam int CAP_MAX    = (1 << CAP_W) - 1;
    localparam int APB_W      = 32;
    localparam int PADDR_W    = 3;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        REG_CAPACITY = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
    } t_cell_ctl;

endpackage

### sv/bdeq_cell.sv
// One storage cell of the queue row: holds one word and shifts with its neighbors.
`timescale 1ns / 1ps

module bdeq_cell
    import bdeq_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int DATA_W = DATA_W_DEF,
    parameter int CNT_W  = 5
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic [DATA_W-1:0] i_left_data,
    input  logic [DATA_W-1:0] i_right_data,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_back_tap
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_is_tail;
    logic              w_is_last;

    assign w_is_tail = (i_count == CNT_W'(IDX));
    assign w_is_last = (i_count == CNT_W'(IDX + 1));

    always_comb begin
        n_data = r_data;
        if (i_ctl.push_front) begin
            n_data = (IDX == 0) ? i_push_data : i_left_data;
        end else if (i_ctl.push_back && w_is_tail) begin
            n_data = i_push_data;
        end else if (i_ctl.pop_front) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_back_tap = w_is_last ? r_data : '0;

endmodule

### sv/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue: command decode, cell row, result register.
// Takes one command per cycle; the result is written to an output register when the command
// is accepted, and a new command is taken whenever that register is empty or
// being drained. Elements live in a row of DEPTH cells with the front in cell 0: a push at
// the front or a pop from the front shifts the whole row by one cell in that same cycle, a
// push at the back writes the cell at the count, and a pop from the back reads the cell
// below the count through an AND-OR of per-cell taps. The capacity register is read and
// written over the APB port at byte address 0.
`timescale 1ns / 1ps

module bounded_double_ended_queue
    import bdeq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [DATA_W-1:0]  i_element_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [DATA_W-1:0]  o_element_out,
    output logic [CNT_W-1:0]   o_count_now,
    output logic [CNT_W-1:0]   o_room_left,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_RST = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

    logic [CAP_W-1:0]  r_capacity;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_element;
    logic [DATA_W-1:0] n_element;
    logic [CNT_W-1:0]  r_room;
    logic [CNT_W-1:0]  n_room;

    logic              w_accept;
    logic              w_cfg_wr;
    t_cmd              w_cmd;
    logic [CNT_W-1:0]  w_eff_cap;
    logic              w_full;
    logic              w_empty;
    t_cell_ctl         w_ctl;
    logic [DATA_W-1:0] w_back_data;

    logic [DATA_W-1:0] w_cell_data [DEPTH];
    logic [DATA_W-1:0] w_cell_tap  [DEPTH];

    assign pready   = 1'b1;
    assign prdata   = APB_W'(r_capacity);
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (t_reg_idx'(paddr[2]) == REG_CAPACITY);

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_cmd    = t_cmd'(i_cmd);

    assign w_eff_cap = (CMP_W'(r_capacity) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                              : CNT_W'(r_capacity);
    assign w_full    = (r_count >= w_eff_cap);
    assign w_empty   = (r_count == '0);

    always_comb begin
        w_ctl.push_front = w_accept && (w_cmd == CMD_PUSH_FRONT) && !w_full;
        w_ctl.push_back  = w_accept && (w_cmd == CMD_PUSH_BACK)  && !w_full;
        w_ctl.pop_front  = w_accept && (w_cmd == CMD_POP_FRONT)  && !w_empty;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        localparam int RIGHT = (g == DEPTH - 1) ? g : g + 1;
        bdeq_cell #(
            .IDX    (g),
            .DATA_W (DATA_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_push_data  (i_element_in),
            .i_left_data  (w_cell_data[LEFT]),
            .i_right_data (w_cell_data[RIGHT]),
            .o_data       (w_cell_data[g]),
            .o_back_tap   (w_cell_tap[g])
        );
    end

    always_comb begin
        w_back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_data = w_back_data | w_cell_tap[i];
        end
    end

    always_comb begin
        n_count   = r_count;
        n_status  = ST_DONE;
        n_element = '0;
        case (w_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count   = r_count - CNT_W'(1);
                    n_element = w_cell_data[0];
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count   = r_count - CNT_W'(1);
                    n_element = w_back_data;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
        n_room = (w_eff_cap > n_count) ? (w_eff_cap - n_count) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_W'(CAP_RST);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_capacity <= pwdata[CAP_W-1:0];
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_element <= n_element;
            r_room    <= n_room;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_element_out = r_element;
    assign o_count_now   = r_count;
    assign o_room_left   = r_room;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(DEPTH))
        else $error("held count above depth");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> (o_count_now == '0))
        else $error("empty status with items held");

    a_full_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_room_left == '0))
        else $error("full status with room left");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted item produced no result");

endmodule
